// ----- hw/rtl/meda_pkg.sv -----
// Shared types, codes and constants of the meter energy delta accumulator.
package meda_pkg;

  localparam int KIND_COUNT       = 5;
  localparam int READ_BITS        = 32;
  localparam int OUT_BITS         = 48;
  localparam int DEF_PHASE_COUNT  = 4;
  localparam int DEF_TOTAL_BITS   = 48;
  localparam logic [READ_BITS-1:0] DELTA_LIMIT_RESET = 32'd1000000;

  // Input beat layout (tdata), lowest bit first.
  localparam int IN_DATA_BITS = 216;
  localparam int OFS_PHASE    = 0;
  localparam int OFS_READING  = 2;
  localparam int OFS_DAY      = 162;
  localparam int OFS_WEEK     = 167;
  localparam int OFS_MONTH    = 173;
  localparam int OFS_AUTH     = 177;

  // Result beat layout (tdata): nine 48-bit figures.
  localparam int OUT_DATA_BITS = 9 * OUT_BITS;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_INIT   = 2'd2
  } mode_t;

  typedef enum logic {
    CFG_DELTA_LIMIT = 1'b0,
    CFG_CLEAR_KEY   = 1'b1
  } cfg_idx_t;

  // Commands from the item decode to the period tracker.
  typedef struct packed {
    logic       upd;
    logic       clr;
    logic       init;
    logic [4:0] day;
    logic [5:0] week;
    logic [3:0] month;
  } per_ctl_t;

  // Status returned by the period tracker.
  typedef struct packed {
    logic enabled;
    logic rollover;
  } per_sts_t;

endpackage

// ----- hw/rtl/meda_lane.sv -----
// One reading lane: increase over the previous reading, bound check and saturating add.
module meda_lane #(
  parameter int TOTAL_BITS = meda_pkg::DEF_TOTAL_BITS
) (
  input  logic [meda_pkg::READ_BITS-1:0] reading,
  input  logic [meda_pkg::READ_BITS-1:0] prev,
  input  logic [meda_pkg::READ_BITS-1:0] delta_limit,
  input  logic [TOTAL_BITS-1:0]          total,
  output logic [TOTAL_BITS-1:0]          total_nxt
);
  import meda_pkg::*;

  logic [READ_BITS-1:0]  diff;
  logic                  take;
  logic [TOTAL_BITS:0]   sum;

  // Only an increase strictly inside the limit is added; the sum saturates.
  always_comb begin
    diff = reading - prev;
    take = (reading > prev) && (diff < delta_limit);
    sum  = {1'b0, total} + (TOTAL_BITS + 1)'(diff);
    if (!take) begin
      total_nxt = total;
    end else if (sum[TOTAL_BITS]) begin
      total_nxt = '1;
    end else begin
      total_nxt = sum[TOTAL_BITS-1:0];
    end
  end

endmodule

// ----- hw/rtl/meda_period.sv -----
// Calendar tracking, period start marks and the today, yesterday, week and month figures.
module meda_period #(
  parameter int TOTAL_BITS = meda_pkg::DEF_TOTAL_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  meda_pkg::per_ctl_t  ctl,
  input  logic [TOTAL_BITS-1:0] ia0_old,
  input  logic [TOTAL_BITS-1:0] ia0_new,
  output meda_pkg::per_sts_t  sts,
  output logic [TOTAL_BITS-1:0] today_nxt,
  output logic [TOTAL_BITS-1:0] yest_nxt,
  output logic [TOTAL_BITS-1:0] week_tot_nxt,
  output logic [TOTAL_BITS-1:0] month_tot_nxt
);
  import meda_pkg::*;

  logic [4:0] day_r, day_nxt;
  logic [5:0] week_r, week_nxt;
  logic [3:0] month_r, month_nxt;
  logic       enabled_r, enabled_nxt;
  logic [TOTAL_BITS-1:0] mark_day_r, mark_day_nxt;
  logic [TOTAL_BITS-1:0] mark_week_r, mark_week_nxt;
  logic [TOTAL_BITS-1:0] mark_month_r, mark_month_nxt;
  logic [TOTAL_BITS-1:0] today_r, yest_r, week_tot_r, month_tot_r;
  logic       day_chg, week_chg, month_chg;

  function automatic logic [TOTAL_BITS-1:0] since(input logic [TOTAL_BITS-1:0] tot,
                                                  input logic [TOTAL_BITS-1:0] mark);
    return (tot > mark) ? tot - mark : '0;
  endfunction

  // A calendar change takes a new start mark from the old phase-0 total.
  always_comb begin
    day_chg   = ctl.upd && (ctl.day != day_r);
    week_chg  = ctl.upd && (ctl.week != week_r);
    month_chg = ctl.upd && (ctl.month != month_r);

    mark_day_nxt   = ctl.clr ? '0 : (day_chg ? ia0_old : mark_day_r);
    mark_week_nxt  = ctl.clr ? '0 : (week_chg ? ia0_old : mark_week_r);
    mark_month_nxt = ctl.clr ? '0 : (month_chg ? ia0_old : mark_month_r);

    if (ctl.clr) begin
      today_nxt     = '0;
      yest_nxt      = '0;
      week_tot_nxt  = '0;
      month_tot_nxt = '0;
    end else if (ctl.upd) begin
      today_nxt     = since(ia0_new, mark_day_nxt);
      yest_nxt      = day_chg ? today_r : yest_r;
      week_tot_nxt  = since(ia0_new, mark_week_nxt);
      month_tot_nxt = since(ia0_new, mark_month_nxt);
    end else begin
      today_nxt     = today_r;
      yest_nxt      = yest_r;
      week_tot_nxt  = week_tot_r;
      month_tot_nxt = month_tot_r;
    end

    day_nxt     = (ctl.init || day_chg) ? ctl.day : day_r;
    week_nxt    = (ctl.init || week_chg) ? ctl.week : week_r;
    month_nxt   = (ctl.init || month_chg) ? ctl.month : month_r;
    enabled_nxt = enabled_r || ctl.init;

    sts.enabled  = enabled_r;
    sts.rollover = day_chg || week_chg || month_chg;
  end

  // Period state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r        <= '0;
      week_r       <= '0;
      month_r      <= '0;
      enabled_r    <= 1'b0;
      mark_day_r   <= '0;
      mark_week_r  <= '0;
      mark_month_r <= '0;
      today_r      <= '0;
      yest_r       <= '0;
      week_tot_r   <= '0;
      month_tot_r  <= '0;
    end else begin
      day_r        <= day_nxt;
      week_r       <= week_nxt;
      month_r      <= month_nxt;
      enabled_r    <= enabled_nxt;
      mark_day_r   <= mark_day_nxt;
      mark_week_r  <= mark_week_nxt;
      mark_month_r <= mark_month_nxt;
      today_r      <= today_nxt;
      yest_r       <= yest_nxt;
      week_tot_r   <= week_tot_nxt;
      month_tot_r  <= month_tot_nxt;
    end
  end

endmodule

// ----- hw/rtl/meter_energy_delta_accumulator.sv -----
// Top level of the meter energy delta accumulator: item register, totals file and result register.
// The block takes one beat per clock cycle while the result register is free or drains: a beat
// is captured in the input register at the accepting edge, the five reading lanes, the
// totals register file read-modify-write and the period tracker all settle in the following
// cycle, and the result register loads at the next edge and holds the figures until the sink
// takes them. A stalled result register holds the input register back, so at most two items are
// in flight.
// Configuration writes take effect at the clock edge where cfg_we is high; the registers are to
// be written while no item is in flight.
module meter_energy_delta_accumulator #(
  parameter int PHASE_COUNT = meda_pkg::DEF_PHASE_COUNT,
  parameter int TOTAL_BITS  = meda_pkg::DEF_TOTAL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  meda_pkg::cfg_idx_t                  cfg_index,
  input  logic [meda_pkg::READ_BITS-1:0]      cfg_wdata,
  // Input beats.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata, lowest bit up: phase, import_active_reading, export_active_reading,
  // import_reactive_reading, export_reactive_reading, apparent_reading, day_of_month,
  // week_of_year, month_index, auth_code, zero fill.
  input  logic [meda_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // tuser: mode.
  input  logic [1:0]                          in_tuser,
  // Result beats.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata, lowest bit up: import_active_total, export_active_total, import_reactive_total,
  // export_reactive_total, apparent_total, today_total, yesterday_total, week_total,
  // month_total.
  output logic [meda_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // tuser, lowest bit up: rollover, accepted.
  output logic [1:0]                          out_tuser
);
  import meda_pkg::*;

  localparam int PIDX_W = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;

  // Configuration registers.
  logic [READ_BITS-1:0] delta_limit_r;
  logic [READ_BITS-1:0] clear_key_r;

  // Input register.
  logic                    s1_valid_r;
  logic [IN_DATA_BITS-1:0] s1_data_r;
  logic [1:0]              s1_user_r;

  // Result register.
  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic [1:0]               out_user_r, out_user_nxt;

  // Totals and previous readings, one row per reading kind.
  logic [TOTAL_BITS-1:0] tot_r  [KIND_COUNT][PHASE_COUNT];
  logic [READ_BITS-1:0]  prev_r [KIND_COUNT][PHASE_COUNT];

  logic                  adv;
  logic [1:0]            s1_phase;
  logic [PIDX_W+1:0]     phase_ext;
  logic [PIDX_W-1:0]     pidx;
  logic                  phase_ok;
  logic                  is_upd, is_clr, is_init;
  logic [READ_BITS-1:0]  s1_rd [KIND_COUNT];
  logic [READ_BITS-1:0]  s1_auth;
  logic [TOTAL_BITS-1:0] lane_nxt [KIND_COUNT];
  logic [TOTAL_BITS-1:0] phase_tot [KIND_COUNT];
  logic [TOTAL_BITS-1:0] ia0_new;
  logic [TOTAL_BITS-1:0] today_nxt, yest_nxt, week_tot_nxt, month_tot_nxt;
  per_ctl_t              per_ctl;
  per_sts_t              per_sts;

  function automatic logic [OUT_BITS-1:0] to_out(input logic [TOTAL_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_BITS-1:0];
  endfunction

  // Handshake: the input register moves on whenever the result register is free or drains.
  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_limit_r <= DELTA_LIMIT_RESET;
      clear_key_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELTA_LIMIT: delta_limit_r <= cfg_wdata;
        CFG_CLEAR_KEY:   clear_key_r   <= cfg_wdata;
        default:         delta_limit_r <= delta_limit_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
  end

  // Field unpacking and item decode.
  always_comb begin
    s1_phase  = s1_data_r[OFS_PHASE +: 2];
    phase_ext = {{PIDX_W{1'b0}}, s1_phase};
    pidx      = phase_ext[PIDX_W-1:0];
    phase_ok  = {30'd0, s1_phase} < 32'(PHASE_COUNT);
    s1_auth   = s1_data_r[OFS_AUTH +: READ_BITS];
    for (int k = 0; k < KIND_COUNT; k++) begin
      s1_rd[k] = s1_data_r[OFS_READING + READ_BITS * k +: READ_BITS];
    end
    is_upd  = 1'b0;
    is_clr  = 1'b0;
    is_init = 1'b0;
    case (mode_t'(s1_user_r))
      MODE_UPDATE: is_upd  = 1'b1;
      MODE_CLEAR:  is_clr  = 1'b1;
      MODE_INIT:   is_init = 1'b1;
      default:     is_upd  = 1'b0;
    endcase
    per_ctl.upd   = adv && is_upd && phase_ok && per_sts.enabled;
    per_ctl.clr   = adv && is_clr && phase_ok && (s1_auth == clear_key_r);
    per_ctl.init  = adv && is_init && phase_ok;
    per_ctl.day   = s1_data_r[OFS_DAY +: 5];
    per_ctl.week  = s1_data_r[OFS_WEEK +: 6];
    per_ctl.month = s1_data_r[OFS_MONTH +: 4];
  end

  // Five reading lanes on the addressed phase row.
  for (genvar k = 0; k < KIND_COUNT; k++) begin : g_lane
    meda_lane #(
      .TOTAL_BITS(TOTAL_BITS)
    ) u_lane (
      .reading    (s1_rd[k]),
      .prev       (prev_r[k][pidx]),
      .delta_limit(delta_limit_r),
      .total      (tot_r[k][pidx]),
      .total_nxt  (lane_nxt[k])
    );
  end

  // The phase-0 import active total after this item feeds the period figures.
  assign ia0_new = (per_ctl.upd && (s1_phase == 2'd0)) ? lane_nxt[0] : tot_r[0][0];

  meda_period #(
    .TOTAL_BITS(TOTAL_BITS)
  ) u_period (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (per_ctl),
    .ia0_old      (tot_r[0][0]),
    .ia0_new      (ia0_new),
    .sts          (per_sts),
    .today_nxt    (today_nxt),
    .yest_nxt     (yest_nxt),
    .week_tot_nxt (week_tot_nxt),
    .month_tot_nxt(month_tot_nxt)
  );

  // Totals file: cleared by reset or an authorised clear, one phase entry of every row written per update.
  always_ff @(posedge clk) begin
    if (!rst_n || per_ctl.clr) begin
      for (int k = 0; k < KIND_COUNT; k++) begin
        for (int p = 0; p < PHASE_COUNT; p++) begin
          tot_r[k][p]  <= '0;
          prev_r[k][p] <= '0;
        end
      end
    end else if (per_ctl.upd) begin
      for (int k = 0; k < KIND_COUNT; k++) begin
        tot_r[k][pidx]  <= lane_nxt[k];
        prev_r[k][pidx] <= s1_rd[k];
      end
    end
  end

  // Result assembly from the state after the item.
  always_comb begin
    for (int k = 0; k < KIND_COUNT; k++) begin
      if (!phase_ok || per_ctl.clr) begin
        phase_tot[k] = '0;
      end else if (per_ctl.upd) begin
        phase_tot[k] = lane_nxt[k];
      end else begin
        phase_tot[k] = tot_r[k][pidx];
      end
      out_data_nxt[OUT_BITS * k +: OUT_BITS] = to_out(phase_tot[k]);
    end
    out_data_nxt[OUT_BITS * 5 +: OUT_BITS] = to_out(today_nxt);
    out_data_nxt[OUT_BITS * 6 +: OUT_BITS] = to_out(yest_nxt);
    out_data_nxt[OUT_BITS * 7 +: OUT_BITS] = to_out(week_tot_nxt);
    out_data_nxt[OUT_BITS * 8 +: OUT_BITS] = to_out(month_tot_nxt);
    out_user_nxt[0] = per_sts.rollover;
    out_user_nxt[1] = per_ctl.upd || per_ctl.clr || per_ctl.init;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

// ----- dv/meter_energy_delta_accumulator_test.sv -----
// Self-checking testbench of the meter energy delta accumulator, with its own predictor.
module meter_energy_delta_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import meda_pkg::*;

  // Mode code that the block has no use for; it must be ignored.
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic [OUT_BITS-1:0] TOTAL_MAX = '1;
  localparam int FIG_TODAY     = 5;
  localparam int FIG_YESTERDAY = 6;
  localparam int FIG_WEEK      = 7;
  localparam int FIG_MONTH     = 8;
  localparam int PLAN_COUNT    = 6;

  // One input beat as the testbench sees it; settle holds it back until all results are in.
  typedef struct packed {
    logic [1:0]                        mode;
    logic [1:0]                        phase;
    logic [KIND_COUNT-1:0][READ_BITS-1:0] reading;
    logic [4:0]                        day;
    logic [5:0]                        week;
    logic [3:0]                        month;
    logic [31:0]                       auth;
    logic                              settle;
  } meter_beat_t;

  // One result beat: five phase totals, then today, yesterday, week and month.
  typedef struct packed {
    logic [8:0][OUT_BITS-1:0] figure;
    logic                     rollover;
    logic                     accepted;
  } meter_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  cfg_idx_t                 cfg_index = CFG_DELTA_LIMIT;
  logic [READ_BITS-1:0]     cfg_wdata = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  // tdata, lowest bit up: phase, five readings, day, week, month, auth_code, zero fill.
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  // tuser: mode.
  logic [1:0]               in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  // tdata, lowest bit up: five phase totals, today, yesterday, week, month.
  logic [OUT_DATA_BITS-1:0] out_tdata;
  // tuser, lowest bit up: rollover, accepted.
  logic [1:0]               out_tuser;

  meter_energy_delta_accumulator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predictor state and its copy of the configuration registers.
  logic [OUT_BITS-1:0]  energy_total [KIND_COUNT][DEF_PHASE_COUNT];
  logic [READ_BITS-1:0] last_reading [KIND_COUNT][DEF_PHASE_COUNT];
  logic [OUT_BITS-1:0]  period_mark [3];
  logic [OUT_BITS-1:0]  today_sum, yesterday_sum, week_sum, month_sum;
  logic [4:0]           tracked_day = '0;
  logic [5:0]           tracked_week = '0;
  logic [3:0]           tracked_month = '0;
  logic                 meter_enabled = 1'b0;
  logic [READ_BITS-1:0] delta_limit = DELTA_LIMIT_RESET;
  logic [READ_BITS-1:0] clear_key = '0;

  // Stimulus bookkeeping: readings last sent per lane, and the calendar being walked.
  logic [READ_BITS-1:0] sent_reading [KIND_COUNT][DEF_PHASE_COUNT];
  logic [4:0]           gen_day = 5'd1;
  logic [5:0]           gen_week = '0;
  logic [3:0]           gen_month = '0;

  meter_beat_t   beat_backlog [$];
  meter_result_t predicted_results [$];
  int            beats_queued = 0;
  int            beats_taken = 0;
  int            results_checked = 0;
  int            accepted_seen = 0;
  int            rollovers_seen = 0;
  int            error_count = 0;
  bit            calm = 1'b0;
  string         figure_label [9] = '{"import_active_total", "export_active_total",
                                      "import_reactive_total", "export_reactive_total",
                                      "apparent_total", "today_total", "yesterday_total",
                                      "week_total", "month_total"};

  task automatic report_error(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic void clear_meter_state();
    for (int k = 0; k < KIND_COUNT; k++) begin
      for (int p = 0; p < DEF_PHASE_COUNT; p++) begin
        energy_total[k][p] = '0;
        last_reading[k][p] = '0;
      end
    end
    for (int i = 0; i < 3; i++) period_mark[i] = '0;
    today_sum = '0;
    yesterday_sum = '0;
    week_sum = '0;
    month_sum = '0;
  endfunction

  function automatic logic [OUT_BITS-1:0] since_mark(logic [OUT_BITS-1:0] total,
                                                      logic [OUT_BITS-1:0] mark);
    return (total > mark) ? total - mark : '0;
  endfunction

  // Applies one accepted beat to the predictor state and returns the result it should give.
  function automatic meter_result_t account_beat(meter_beat_t b);
    meter_result_t        r;
    logic [OUT_BITS-1:0]  ia0;
    logic [OUT_BITS-1:0]  t;
    logic [OUT_BITS-1:0]  d;
    logic [READ_BITS-1:0] prev;
    r = '0;
    case (b.mode)
      MODE_UPDATE: begin
        if (meter_enabled) begin
          r.accepted = 1'b1;
          // A calendar change closes the period and marks where the new one starts.
          ia0 = energy_total[0][0];
          if (b.day != tracked_day) begin
            yesterday_sum = today_sum;
            today_sum = '0;
            period_mark[0] = ia0;
            tracked_day = b.day;
            r.rollover = 1'b1;
          end
          if (b.week != tracked_week) begin
            week_sum = '0;
            period_mark[1] = ia0;
            tracked_week = b.week;
            r.rollover = 1'b1;
          end
          if (b.month != tracked_month) begin
            month_sum = '0;
            period_mark[2] = ia0;
            tracked_month = b.month;
            r.rollover = 1'b1;
          end
          // Only a plausible increase counts; the reading is always kept.
          for (int k = 0; k < KIND_COUNT; k++) begin
            prev = last_reading[k][b.phase];
            if (b.reading[k] > prev) begin
              d = {16'b0, b.reading[k] - prev};
              if (d < {16'b0, delta_limit}) begin
                t = energy_total[k][b.phase];
                energy_total[k][b.phase] = (t > TOTAL_MAX - d) ? TOTAL_MAX : t + d;
              end
            end
            last_reading[k][b.phase] = b.reading[k];
          end
          ia0 = energy_total[0][0];
          today_sum = since_mark(ia0, period_mark[0]);
          week_sum = since_mark(ia0, period_mark[1]);
          month_sum = since_mark(ia0, period_mark[2]);
        end
      end
      MODE_CLEAR: begin
        if (b.auth == clear_key) begin
          clear_meter_state();
          r.accepted = 1'b1;
        end
      end
      MODE_INIT: begin
        tracked_day = b.day;
        tracked_week = b.week;
        tracked_month = b.month;
        meter_enabled = 1'b1;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    for (int k = 0; k < KIND_COUNT; k++) r.figure[k] = energy_total[k][b.phase];
    r.figure[FIG_TODAY] = today_sum;
    r.figure[FIG_YESTERDAY] = yesterday_sum;
    r.figure[FIG_WEEK] = week_sum;
    r.figure[FIG_MONTH] = month_sum;
    return r;
  endfunction

  // Queues a beat and keeps the record of what each reading lane was last sent.
  function automatic void queue_beat(meter_beat_t b);
    beat_backlog.push_back(b);
    beats_queued++;
    if (b.mode == MODE_UPDATE) begin
      for (int k = 0; k < KIND_COUNT; k++) sent_reading[k][b.phase] = b.reading[k];
    end else if (b.mode == MODE_CLEAR && b.auth == clear_key) begin
      for (int k = 0; k < KIND_COUNT; k++) begin
        for (int p = 0; p < DEF_PHASE_COUNT; p++) sent_reading[k][p] = '0;
      end
    end
  endfunction

  function automatic void queue_directed(logic [1:0] mode, logic [1:0] phase,
                                         logic [31:0] base, logic [4:0] day,
                                         logic [5:0] week, logic [3:0] month,
                                         logic [31:0] auth, bit drain = 1'b0);
    meter_beat_t b;
    b.mode = mode;
    b.phase = phase;
    for (int k = 0; k < KIND_COUNT; k++) b.reading[k] = base + 32'(3 * k);
    b.day = day;
    b.week = week;
    b.month = month;
    b.auth = auth;
    b.settle = drain;
    queue_beat(b);
  endfunction

  // Waits until every queued beat has been taken and every result has come back.
  task automatic wait_for_quiet();
    do @(negedge clk);
    while (beats_taken != beats_queued || predicted_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [READ_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DELTA_LIMIT) delta_limit = value;
    else clear_key = value;
  endtask

  // Input driver: predicts each beat as it is taken and presents the next one.
  always @(posedge clk) begin : beat_feeder
    meter_beat_t     on_bus;
    int              send_idle;
    logic [IN_DATA_BITS-1:0] packed_beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_idle = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_results.push_back(account_beat(on_bus));
        beats_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_idle > 0) begin
          send_idle--;
          in_tvalid <= 1'b0;
        end else if (beat_backlog.size() > 0 &&
                     !(beat_backlog[0].settle && predicted_results.size() != 0)) begin
          on_bus = beat_backlog.pop_front();
          packed_beat = '0;
          packed_beat[OFS_PHASE +: 2] = on_bus.phase;
          for (int k = 0; k < KIND_COUNT; k++)
            packed_beat[OFS_READING + READ_BITS * k +: READ_BITS] = on_bus.reading[k];
          packed_beat[OFS_DAY +: 5] = on_bus.day;
          packed_beat[OFS_WEEK +: 6] = on_bus.week;
          packed_beat[OFS_MONTH +: 4] = on_bus.month;
          packed_beat[OFS_AUTH +: 32] = on_bus.auth;
          in_tvalid <= 1'b1;
          in_tdata <= packed_beat;
          in_tuser <= on_bus.mode;
          if (!calm && $urandom_range(0, 15) == 0) send_idle = $urandom_range(1, 16);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result beat with the oldest prediction, field by field.
  always @(posedge clk) begin : result_sink
    meter_result_t want;
    int            sink_stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          report_error("result beat arrived with no prediction outstanding");
        end else begin
          want = predicted_results.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (out_tdata[i * OUT_BITS +: OUT_BITS] !== want.figure[i])
              report_error($sformatf("result %0d %s: got %0d, expected %0d", results_checked,
                                     figure_label[i], out_tdata[i * OUT_BITS +: OUT_BITS],
                                     want.figure[i]));
          end
          if (out_tuser[0] !== want.rollover)
            report_error($sformatf("result %0d rollover: got %b, expected %b", results_checked,
                                   out_tuser[0], want.rollover));
          if (out_tuser[1] !== want.accepted)
            report_error($sformatf("result %0d accepted: got %b, expected %b", results_checked,
                                   out_tuser[1], want.accepted));
        end
        results_checked++;
        if (out_tuser[1] === 1'b1) accepted_seen++;
        if (out_tuser[0] === 1'b1) rollovers_seen++;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        sink_stall = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: a directed opening at reset settings, then random phases under several settings.
  initial begin : stimulus
    logic [READ_BITS-1:0] limit_plan [PLAN_COUNT];
    logic [READ_BITS-1:0] key_plan [PLAN_COUNT];
    int                   count_plan [PLAN_COUNT];
    meter_beat_t          b;
    logic [READ_BITS-1:0] prev;
    int                   pick;
    int                   roll;
    clear_meter_state();
    for (int k = 0; k < KIND_COUNT; k++) begin
      for (int p = 0; p < DEF_PHASE_COUNT; p++) sent_reading[k][p] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Before init an update is refused; an unused mode and a wrong key do nothing.
    queue_directed(MODE_UPDATE, 2'd0, 32'd100, 5'd1, 6'd0, 4'd0, 32'd0);
    queue_directed(MODE_IGNORED, 2'd2, 32'hFFFF_FFFF, 5'd31, 6'd63, 4'd15, 32'hFFFF_FFFF);
    queue_directed(MODE_CLEAR, 2'd1, 32'd0, 5'd0, 6'd0, 4'd0, 32'd1);
    queue_directed(MODE_INIT, 2'd0, 32'd0, 5'd1, 6'd0, 4'd0, 32'd0);
    // Increases just inside and exactly at the limit, a fall and no change.
    queue_directed(MODE_UPDATE, 2'd0, 32'd500, 5'd1, 6'd0, 4'd0, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd1000499, 5'd1, 6'd0, 4'd0, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd2000499, 5'd1, 6'd0, 4'd0, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd1000, 5'd1, 6'd0, 4'd0, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd1000, 5'd1, 6'd0, 4'd0, 32'd0);
    // Day, week and month changes, alone and together.
    queue_directed(MODE_UPDATE, 2'd0, 32'd1001, 5'd2, 6'd0, 4'd0, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd3000, 5'd2, 6'd1, 4'd0, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd5000, 5'd2, 6'd1, 4'd1, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd9000, 5'd3, 6'd2, 4'd2, 32'd0);
    // Other phases: a huge jump, a fall, a clean first increase, an out-of-range calendar; then a re-init.
    queue_directed(MODE_UPDATE, 2'd1, 32'hFFFF_FFFF, 5'd3, 6'd2, 4'd2, 32'd0);
    queue_directed(MODE_UPDATE, 2'd1, 32'd40, 5'd3, 6'd2, 4'd2, 32'd0);
    queue_directed(MODE_UPDATE, 2'd3, 32'd999990, 5'd3, 6'd2, 4'd2, 32'd0);
    queue_directed(MODE_UPDATE, 2'd2, 32'd12345, 5'd0, 6'd63, 4'd15, 32'd0);
    queue_directed(MODE_INIT, 2'd3, 32'd0, 5'd31, 6'd52, 4'd11, 32'd0, 1'b1);
    queue_directed(MODE_UPDATE, 2'd0, 32'd20000, 5'd31, 6'd52, 4'd11, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd30000, 5'd1, 6'd52, 4'd11, 32'd0);
    // A matching key wipes the totals but keeps the calendar.
    queue_directed(MODE_CLEAR, 2'd2, 32'd0, 5'd0, 6'd0, 4'd0, 32'd0);
    queue_directed(MODE_UPDATE, 2'd0, 32'd100, 5'd1, 6'd52, 4'd11, 32'd0);
    queue_directed(MODE_UPDATE, 2'd1, 32'd0, 5'd1, 6'd52, 4'd11, 32'd0);
    gen_day = 5'd1;
    gen_week = 6'd52;
    gen_month = 4'd11;
    wait_for_quiet();

    limit_plan = '{32'd1000000, 32'd0, 32'hFFFF_FFFF, 32'd1,
                   32'($urandom_range(2, 5000)), 32'd1000000};
    key_plan = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'hA5A5_5A5A, $urandom, 32'h1234_5678};
    count_plan = '{350, 200, 400, 200, 350, 400};

    for (int s = 0; s < PLAN_COUNT; s++) begin
      write_register(CFG_DELTA_LIMIT, limit_plan[s]);
      write_register(CFG_CLEAR_KEY, key_plan[s]);
      calm = (s == PLAN_COUNT - 1);
      for (int n = 0; n < count_plan[s]; n++) begin
        b = '0;
        pick = $urandom_range(0, 99);
        b.phase = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'($urandom_range(0, 3));
        b.auth = $urandom;
        b.settle = !calm && ($urandom_range(0, 63) == 0);
        if (pick < 84) begin
          // Mostly plausible readings, with edges of the limit, falls and wild values mixed in.
          b.mode = MODE_UPDATE;
          for (int k = 0; k < KIND_COUNT; k++) begin
            prev = sent_reading[k][b.phase];
            roll = $urandom_range(0, 99);
            if (roll < 65) b.reading[k] = prev + 32'($urandom_range(1, 4000));
            else if (roll < 72) b.reading[k] = prev;
            else if (roll < 78) b.reading[k] = prev + delta_limit - 32'd1;
            else if (roll < 84) b.reading[k] = prev + delta_limit + 32'($urandom_range(0, 2));
            else if (roll < 92) b.reading[k] = prev - 32'($urandom_range(1, 5000));
            else b.reading[k] = $urandom;
          end
          if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
              0: gen_day = 5'($urandom_range(1, 31));
              1: gen_week = 6'($urandom_range(0, 52));
              2: gen_month = 4'($urandom_range(0, 11));
              default: begin
                gen_day = 5'($urandom);
                gen_week = 6'($urandom);
                gen_month = 4'($urandom);
              end
            endcase
          end
        end else if (pick < 90) begin
          b.mode = MODE_CLEAR;
          if ($urandom_range(0, 1) == 1) b.auth = clear_key;
        end else if (pick < 95) begin
          b.mode = MODE_INIT;
          gen_day = 5'($urandom);
          gen_week = 6'($urandom);
          gen_month = 4'($urandom);
        end else if (pick < 97) begin
          b.mode = MODE_IGNORED;
          for (int k = 0; k < KIND_COUNT; k++) b.reading[k] = $urandom;
        end else begin
          // Noise: anything the fields allow.
          b.mode = 2'($urandom_range(0, 3));
          for (int k = 0; k < KIND_COUNT; k++) b.reading[k] = $urandom;
          gen_day = 5'($urandom);
          gen_week = 6'($urandom);
          gen_month = 4'($urandom);
        end
        b.day = gen_day;
        b.week = gen_week;
        b.month = gen_month;
        queue_beat(b);
      end
      wait_for_quiet();
    end

    repeat (8) @(posedge clk);
    $display("Summary: %0d beats sent, directed then random under %0d limit and key settings;",
             beats_taken, PLAN_COUNT);
    $display("%0d results checked, %0d accepted, %0d with a calendar rollover.",
             results_checked, accepted_seen, rollovers_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (about 1900 beats with full idling).
  initial begin : watchdog
    #5ms;
    $display("Timeout: %0d of %0d beats taken, %0d results outstanding.",
             beats_taken, beats_queued, predicted_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/meda_pkg.sv
hw/rtl/meda_lane.sv
hw/rtl/meda_period.sv
hw/rtl/meter_energy_delta_accumulator.sv
dv/meter_energy_delta_accumulator_test.sv
